@@ rtl/core/bsd_pkg.sv @@
`timescale 1ns / 1ps

package bsd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 12;

  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_IN   = 2'd1,
    MODE_ESC  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic [BYTE_W-1:0]   payload;
    logic [LEN_W-1:0]    frame_length;
  } res_t;

  localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd125;

endpackage

@@ rtl/core/bsd_core.sv @@
`timescale 1ns / 1ps

module bsd_core #(
  parameter int unsigned MAX_FRAME_LEN = 2048
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [bsd_pkg::BYTE_W-1:0] rx_byte,
  input  logic [bsd_pkg::BYTE_W-1:0] flag_value,
  input  logic [bsd_pkg::BYTE_W-1:0] escape_value,
  output bsd_pkg::res_t              res
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_LEN);

  bsd_pkg::mode_t   mode, mode_next;
  logic [CNT_W-1:0] count, count_next;

  logic is_flag, is_escape, full;

  assign is_flag   = (rx_byte == flag_value);
  assign is_escape = (rx_byte == escape_value);
  assign full      = (count >= CNT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= bsd_pkg::MODE_HUNT;
      count <= '0;
    end else if (accept) begin
      mode  <= mode_next;
      count <= count_next;
    end
  end

  // next state
  always_comb begin
    mode_next  = bsd_pkg::MODE_HUNT;
    count_next = '0;
    case (mode)
      bsd_pkg::MODE_IN: begin
        if (is_flag) begin
          mode_next = bsd_pkg::MODE_HUNT;
        end else if (is_escape) begin
          mode_next  = bsd_pkg::MODE_ESC;
          count_next = count;
        end else if (!full) begin
          mode_next  = bsd_pkg::MODE_IN;
          count_next = count + CNT_W'(1);
        end
      end
      bsd_pkg::MODE_ESC: begin
        if ((is_flag || is_escape) && !full) begin
          mode_next  = bsd_pkg::MODE_IN;
          count_next = count + CNT_W'(1);
        end
      end
      default: begin
        // hunt: a flag opens a frame, anything else is dropped
        if (is_flag) begin
          mode_next = bsd_pkg::MODE_IN;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res = '{valid: 1'b0, kind: bsd_pkg::KIND_PAYLOAD, payload: '0, frame_length: '0};
    case (mode)
      bsd_pkg::MODE_IN: begin
        if (is_flag) begin
          res.valid        = 1'b1;
          res.kind         = bsd_pkg::KIND_DONE;
          res.frame_length = bsd_pkg::LEN_W'(count);
        end else if (!is_escape) begin
          res.valid = 1'b1;
          if (full) begin
            res.kind = bsd_pkg::KIND_ERROR;
          end else begin
            res.payload = rx_byte;
          end
        end
      end
      bsd_pkg::MODE_ESC: begin
        res.valid = 1'b1;
        if ((is_flag || is_escape) && !full) begin
          res.payload = rx_byte;
        end else begin
          res.kind = bsd_pkg::KIND_ERROR;
        end
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("byte count beyond maximum frame length");

  a_payload_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && res.valid && res.kind == bsd_pkg::KIND_PAYLOAD)
      |=> (count == $past(count) + CNT_W'(1)) && mode == bsd_pkg::MODE_IN)
    else $error("payload transfer did not advance the byte count");

  a_end_hunts: assert property (@(posedge clk) disable iff (rst)
    (accept && res.valid && res.kind != bsd_pkg::KIND_PAYLOAD)
      |=> mode == bsd_pkg::MODE_HUNT && count == '0)
    else $error("frame end or error did not return to hunting");

  a_esc_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && mode_next == bsd_pkg::MODE_ESC) |-> !res.valid)
    else $error("escape byte produced a result");

endmodule

@@ rtl/core/bsd_out_reg.sv @@
`timescale 1ns / 1ps

module bsd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  bsd_pkg::res_t res,
  input  logic          m_tready,
  output logic          m_tvalid,
  output bsd_pkg::res_t held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

@@ rtl/core/byte_stuffing_deframer.sv @@
`timescale 1ns / 1ps
// A result appears on the master side in the cycle after the input transfer.
// One byte per cycle unless a held result waits on m_tready; the single mode/count register update sets it.
// The output register lets a new byte enter while the previous result is taken.
// Reset (rst, synchronous): flag 126, escape 125, hunting, byte count zero,
// output register empty.

module byte_stuffing_deframer #(
  parameter int unsigned MAX_FRAME_LEN = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] payload, [19:8] frame_length, [23:20] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_FLAG   = 1'b0;
  localparam logic REG_ESCAPE = 1'b1;

  logic [bsd_pkg::BYTE_W-1:0] flag_value, escape_value;
  logic                       s_accept, load;
  bsd_pkg::res_t              res, held;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_value   <= bsd_pkg::FLAG_RESET;
      escape_value <= bsd_pkg::ESCAPE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_FLAG:   flag_value   <= pwdata[bsd_pkg::BYTE_W-1:0];
        REG_ESCAPE: escape_value <= pwdata[bsd_pkg::BYTE_W-1:0];
        default:    flag_value   <= flag_value;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FLAG:   prdata = {24'd0, flag_value};
      REG_ESCAPE: prdata = {24'd0, escape_value};
      default:    prdata = '0;
    endcase
  end

  // take a byte whenever the output register is free or drains this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign load     = s_accept && res.valid;

  bsd_core #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (s_accept),
    .rx_byte      (s_tdata),
    .flag_value   (flag_value),
    .escape_value (escape_value),
    .res          (res)
  );

  bsd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .res      (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .held     (held)
  );

  assign m_tdata = {4'd0, held.frame_length, held.payload};
  assign m_tuser = held.kind;

endmodule
